[rtl/core/gated_dual_channel_period_averager_core_assert.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the gated dual channel period averager
// Clocked on clk_i, disabled while rst_ni is low.
// ---------------------------------------------------------------------------
`ifndef GATED_DUAL_CHANNEL_PERIOD_AVERAGER_CORE_ASSERT_SVH
`define GATED_DUAL_CHANNEL_PERIOD_AVERAGER_CORE_ASSERT_SVH

// Same-cycle implication.
`define GDCPA_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("gdcpa: same-cycle check failed");

// Next-cycle implication.
`define GDCPA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("gdcpa: next-cycle check failed");

`endif

[rtl/core/gdcpa_pkg.sv]
// ---------------------------------------------------------------------------
// gdcpa_pkg
// Shared types and constants of the gated dual channel period averager.
// ---------------------------------------------------------------------------
package gdcpa_pkg;

  localparam int unsigned PeriodW = 32;
  localparam int unsigned GateW   = 16;
  localparam int unsigned InDataW  = 56;  // 16 + 1 + 32 = 49, padded to bytes
  localparam int unsigned OutDataW = 96;
  localparam int unsigned DivCntW  = 6;

  localparam logic [GateW-1:0]   GateReset = 16'd20000;
  localparam logic [PeriodW-1:0] AllOnes   = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    FUNC_START   = 2'd0,
    FUNC_END     = 2'd1,
    FUNC_CAPTURE = 2'd2,
    FUNC_OTHER   = 2'd3
  } func_e;

  typedef struct packed {
    logic load_item;
    logic exec;
    logic div_start;
    logic finish;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    func_e func;
    logic  count_zero;
    logic  div_done;
    logic  out_free;
  } ctrl_sts_t;

endpackage

[rtl/core/gdcpa_div.sv]
// ---------------------------------------------------------------------------
// gdcpa_div
// Restoring bit-serial unsigned divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module gdcpa_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [gdcpa_pkg::PeriodW-1:0] dividend_i,
  input  logic [gdcpa_pkg::PeriodW-1:0] divisor_i,
  output logic                          done_o,
  output logic [gdcpa_pkg::PeriodW-1:0] quotient_o
);
  import gdcpa_pkg::*;

  logic [PeriodW-1:0] rem_q, rem_d;
  logic [PeriodW-1:0] quo_q, quo_d;
  logic [PeriodW-1:0] dvs_q, dvs_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [PeriodW:0]   shifted;
  logic [PeriodW:0]   diff;
  logic               ge;

  always_comb begin
    shifted = {rem_q, quo_q[PeriodW-1]};
    diff    = shifted - {1'b0, dvs_q};
    ge      = ~diff[PeriodW];
  end

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
      cnt_d  = DivCntW'(PeriodW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = ge ? diff[PeriodW-1:0] : shifted[PeriodW-1:0];
      quo_d = {quo_q[PeriodW-2:0], ge};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == DivCntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

[rtl/core/gdcpa_dp.sv]
// ---------------------------------------------------------------------------
// gdcpa_dp
// Datapath: item register, gate threshold register, per-channel state, divider and result register.
// ---------------------------------------------------------------------------
module gdcpa_dp (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  gdcpa_pkg::ctrl_cmd_t           cmd_i,
  output gdcpa_pkg::ctrl_sts_t           sts_o,
  input  logic [gdcpa_pkg::InDataW-1:0]  in_data_i,
  input  logic [1:0]                     in_user_i,
  input  logic                           cfg_valid_i,
  input  logic [gdcpa_pkg::GateW-1:0]    cfg_data_i,
  input  logic                           out_ready_i,
  output logic                           out_valid_o,
  output logic [gdcpa_pkg::OutDataW-1:0] out_data_o,
  output logic [1:0]                     out_user_o
);
  import gdcpa_pkg::*;

  // item register
  func_e              func_q;
  logic [GateW-1:0]   gate_q;
  logic               cch_q;
  logic [PeriodW-1:0] period_q;

  logic [GateW-1:0]   thr_q;

  logic [1:0]         open_q;
  logic [1:0]         skip_q;
  logic [PeriodW-1:0] sum_q   [2];
  logic [PeriodW-1:0] cnt_q   [2];
  logic [PeriodW-1:0] avg_q   [2];
  logic [PeriodW-1:0] min_q   [2];
  logic [PeriodW-1:0] max_q   [2];
  logic               fresh_q;

  logic                out_valid_q;
  logic [OutDataW-1:0] out_data_q;
  logic [1:0]          out_user_q;

  logic               below;
  logic               ch;
  logic               div_done;
  logic [PeriodW-1:0] quotient;

  always_comb begin
    below = gate_q < thr_q;
    unique case (func_q)
      FUNC_START: ch = ~below;
      FUNC_END:   ch = below;
      default:    ch = cch_q;
    endcase
  end

  gdcpa_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (sum_q[ch]),
    .divisor_i  (cnt_q[ch]),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      func_q   <= func_e'(in_user_i);
      gate_q   <= in_data_i[15:0];
      cch_q    <= in_data_i[16];
      period_q <= in_data_i[48:17];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= GateReset;
    end else if (cfg_valid_i) begin
      thr_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q  <= '0;
      skip_q  <= '0;
      fresh_q <= 1'b0;
      for (int i = 0; i < 2; i++) begin
        sum_q[i] <= '0;
        cnt_q[i] <= '0;
        avg_q[i] <= '0;
        min_q[i] <= AllOnes;
        max_q[i] <= '0;
      end
    end else begin
      if (cmd_i.exec) begin
        fresh_q <= 1'b0;
        unique case (func_q)
          FUNC_START: open_q[ch] <= 1'b1;
          FUNC_END: begin
            // when the count is nonzero, the divider has taken sum and count at this edge
            open_q[ch] <= 1'b0;
            skip_q[ch] <= 1'b0;
            sum_q[ch]  <= '0;
            cnt_q[ch]  <= '0;
          end
          FUNC_CAPTURE: begin
            if (open_q[ch]) begin
              if (skip_q[ch]) begin
                sum_q[ch] <= sum_q[ch] + period_q;
                cnt_q[ch] <= cnt_q[ch] + 1'b1;
              end else begin
                skip_q[ch] <= 1'b1;
              end
            end
          end
          default: ;
        endcase
      end
      if (cmd_i.finish) begin
        fresh_q   <= 1'b1;
        avg_q[ch] <= quotient;
        if (quotient > max_q[ch]) max_q[ch] <= quotient;
        if (quotient < min_q[ch]) min_q[ch] <= quotient;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_data_q <= {max_q[ch], min_q[ch], avg_q[ch]};
      out_user_q <= {fresh_q, ch};
    end
  end

  always_comb begin
    sts_o.func       = func_q;
    sts_o.count_zero = (cnt_q[ch] == '0);
    sts_o.div_done   = div_done;
    sts_o.out_free   = ~out_valid_q | out_ready_i;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_user_o  = out_user_q;

endmodule

[rtl/core/gdcpa_ctrl.sv]
// ---------------------------------------------------------------------------
// gdcpa_ctrl
// Controller: sequences accept, execute, divide and result load.
// ---------------------------------------------------------------------------
module gdcpa_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  gdcpa_pkg::ctrl_sts_t sts_i,
  output gdcpa_pkg::ctrl_cmd_t cmd_o
);
  import gdcpa_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_EXEC = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_LOAD = 4'b1000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d         = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd_o.exec = 1'b1;
        if (sts_i.func == FUNC_END && !sts_i.count_zero) begin
          cmd_o.div_start = 1'b1;
          state_d         = ST_DIV;
        end else begin
          state_d = ST_LOAD;
        end
      end
      ST_DIV: begin
        if (sts_i.div_done) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[rtl/core/gated_dual_channel_period_averager_core.sv]
// ---------------------------------------------------------------------------
// gated_dual_channel_period_averager_core
// Steps: accept, execute, a divide only for a window end with a nonzero count, then result load.
// A new item is accepted only after the last result is loaded; an output stall can hold that load.
// Reset: async, active low; threshold 20000, windows shut, minima all ones, other channel state zero.
// ---------------------------------------------------------------------------
`include "gated_dual_channel_period_averager_core_assert.svh"

module gated_dual_channel_period_averager_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // input transactions
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // [15:0] gate_count, [16] capture_channel, [48:17] captured_period
  input  logic [gdcpa_pkg::InDataW-1:0]  s_axis_tdata,
  // [1:0] func
  input  logic [1:0]                     s_axis_tuser,
  // gate threshold register write
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [gdcpa_pkg::GateW-1:0]    cfg_data,
  // result transactions
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [31:0] average_period, [63:32] min_period, [95:64] max_period
  output logic [gdcpa_pkg::OutDataW-1:0] m_axis_tdata,
  // [0] report_channel, [1] new_average
  output logic [1:0]                     m_axis_tuser
);
  import gdcpa_pkg::*;

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  // Always ready; the user must send threshold writes only while the block is idle (unenforced).
  assign cfg_ready = 1'b1;

  // Sequence each transaction: accept, execute, optional divide, load result.
  gdcpa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Hold per-channel state and the result register; a pending result
  // that is not taken holds the result load and so the next accept.
  gdcpa_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_data_i   (s_axis_tdata),
    .in_user_i   (s_axis_tuser),
    .cfg_valid_i (cfg_valid),
    .cfg_data_i  (cfg_data),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (m_axis_tdata),
    .out_user_o  (m_axis_tuser)
  );

  // One transaction at a time: no accept straight after an accept.
  `GDCPA_ASSERT_NEXT(a_one_in_flight, s_axis_tvalid && s_axis_tready, !s_axis_tready)

  // A fresh average lies between the channel's running minimum and maximum.
  `GDCPA_ASSERT_NOW(a_fresh_in_range, m_axis_tvalid && m_axis_tuser[1], (m_axis_tdata[31:0] >= m_axis_tdata[63:32]) && (m_axis_tdata[31:0] <= m_axis_tdata[95:64]))

  // A result load always presents a result on the next cycle.
  `GDCPA_ASSERT_NEXT(a_load_shows, cmd.load_out, m_axis_tvalid)

endmodule
